FILE: rtl/scf_pkg.sv
package scf_pkg;

  localparam int DEF_TAPS     = 5;
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam int PIX_W     = 16;
  localparam int COEF_W    = 16;
  localparam int VAL_W     = 24;
  localparam int POS_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int DIM_W     = 13;
  localparam int NCOEF     = 5;
  localparam int CIDX_W    = 3;
  localparam int TAP_MAX_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = VAL_W + COEF_W;
  localparam int ACC_W     = 44;
  localparam int FRAC      = 14;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd6;

  localparam logic signed [COEF_W-1:0] COEF_CENTER_RESET = 16'sd16384;
  localparam logic [CIDX_W-1:0]        COEF_CENTER_IDX   = 3'd2;
  localparam logic [SIZE_W-1:0]        SIZE_RESET        = 11'd1024;

  typedef struct packed {
    logic                 accept;
    logic                 mul_en;
    logic                 pass_v;
    logic [TAP_MAX_W-1:0] tap;
    logic                 acc_clr;
    logic                 mem_wr;
    logic                 out_load;
  } cmd_t;

  typedef struct packed {
    logic h_ok;
    logic v_ok;
    logic out_full;
  } stat_t;

  function automatic logic signed [VAL_W-1:0] sat24(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = acc >>> FRAC;
    if (sh > $signed(ACC_W'(8388607))) begin
      sat24 = 24'sh7FFFFF;
    end else if (sh < -$signed(ACC_W'(8388608))) begin
      sat24 = 24'sh800000;
    end else begin
      sat24 = sh[VAL_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/separable_conv2d_filter.sv
// A pixel with no result stays in IDLE; a horizontal-only item runs HMAC, HFIN, HSAT.
// An item with a result then runs VMAC, VFIN and VOUT; both passes share one multiplier.
// VOUT waits for a free output register; no new pixel is taken until the item is done.
// Throughput is set by the one multiplier that runs both filter passes tap by tap.
// Synchronous reset clears the frame position, the row window, the handshakes and
// restores the register defaults; the line store keeps its contents.
module separable_conv2d_filter #(
  parameter int TAPS     = scf_pkg::DEF_TAPS,
  parameter int MAX_COLS = scf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = scf_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [scf_pkg::IN_DATA_W-1:0]       s_tdata,   // pixel[15:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [scf_pkg::OUT_DATA_W-1:0]      m_tdata,   // value[23:0], out_row[33:24],
                                                         // out_col[43:34], zeros[47:44]
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scf_pkg::COEF_W-1:0]          cfg_data
);

  scf_pkg::cmd_t                     cmd;
  scf_pkg::stat_t                    st;
  logic signed [scf_pkg::VAL_W-1:0]  value;
  logic [scf_pkg::POS_W-1:0]         out_row;
  logic [scf_pkg::POS_W-1:0]         out_col;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {4'b0, out_col, out_row, value};

  scf_ctrl #(
    .TAPS(TAPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  scf_datapath #(
    .TAPS     (TAPS),
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .pixel     (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .value     (value),
    .out_row   (out_row),
    .out_col   (out_col),
    .last      (m_tlast)
  );

endmodule

FILE: rtl/scf_ctrl.sv
module scf_ctrl #(
  parameter int TAPS = scf_pkg::DEF_TAPS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  scf_pkg::stat_t st,
  output scf_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE, HMAC, HFIN, HSAT, VMAC, VFIN, VOUT
  } state_t;

  localparam logic [scf_pkg::TAP_MAX_W-1:0] TAP_LAST = scf_pkg::TAP_MAX_W'(TAPS - 1);

  state_t                          state;
  logic [scf_pkg::TAP_MAX_W-1:0]   tap;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_valid && (state == IDLE);
    cmd.mul_en   = (state == HMAC) || (state == VMAC);
    cmd.pass_v   = (state == VMAC);
    cmd.tap      = tap;
    cmd.acc_clr  = cmd.mul_en && (tap == '0);
    cmd.mem_wr   = (state == HSAT);
    cmd.out_load = (state == VOUT) && !st.out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      tap   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          tap <= '0;
          if (in_valid && st.h_ok) begin
            state <= HMAC;
          end
        end
        HMAC: begin
          if (tap == TAP_LAST) begin
            tap   <= '0;
            state <= HFIN;
          end else begin
            tap <= tap + 1'b1;
          end
        end
        HFIN: state <= HSAT;
        HSAT: begin
          tap   <= '0;
          state <= st.v_ok ? VMAC : IDLE;
        end
        VMAC: begin
          if (tap == TAP_LAST) begin
            tap   <= '0;
            state <= VFIN;
          end else begin
            tap <= tap + 1'b1;
          end
        end
        VFIN: state <= VOUT;
        VOUT: begin
          if (!st.out_full) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/scf_datapath.sv
module scf_datapath #(
  parameter int TAPS     = scf_pkg::DEF_TAPS,
  parameter int MAX_COLS = scf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = scf_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  scf_pkg::cmd_t                      cmd,
  output scf_pkg::stat_t                     st,
  input  logic signed [scf_pkg::PIX_W-1:0]   pixel,
  input  logic                               cfg_we,
  input  logic [scf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scf_pkg::COEF_W-1:0]         cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [scf_pkg::VAL_W-1:0]   value,
  output logic [scf_pkg::POS_W-1:0]          out_row,
  output logic [scf_pkg::POS_W-1:0]          out_col,
  output logic                               last
);

  localparam int HALF  = (TAPS - 1) / 2;
  localparam int POST  = TAPS - 1 - HALF;
  localparam int LINES = TAPS - 1;
  localparam int TAP_W = $clog2(TAPS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int DW    = scf_pkg::DIM_W;
  localparam int VW    = scf_pkg::VAL_W;
  localparam int WORD_W = LINES * VW;

  logic signed [scf_pkg::COEF_W-1:0] coef [scf_pkg::NCOEF];
  logic [scf_pkg::SIZE_W-1:0]        image_width;
  logic [scf_pkg::SIZE_W-1:0]        image_height;

  logic signed [scf_pkg::PIX_W-1:0]  row_window [LINES];
  logic signed [scf_pkg::PIX_W-1:0]  hsamp [TAPS];
  logic [COL_W-1:0]                  col_count;
  logic [ROW_W-1:0]                  row_count;

  logic [WORD_W-1:0]                 mem [MAX_COLS];
  logic [WORD_W-1:0]                 rd_word;
  logic [WORD_W-1:0]                 wr_word;

  logic [COL_W-1:0]                  item_col;
  logic [ROW_W-1:0]                  item_row;
  logic                              item_v;
  logic                              item_last;

  logic signed [VW-1:0]              hres;
  logic signed [scf_pkg::PROD_W-1:0] prod;
  logic                              prod_vld;
  logic signed [scf_pkg::ACC_W-1:0]  acc;
  logic signed [VW-1:0]              acc_sat;

  logic [DW-1:0] w, h, wsz, hsz;
  logic          wrap;
  logic [DW-1:0] cc, rc, i_pos, j_pos;
  logic          h_ok, v_ok, is_last;
  logic          size_we;

  logic signed [VW-1:0]              vsamp [TAPS];
  logic signed [VW-1:0]              opa;
  logic signed [scf_pkg::COEF_W-1:0] opb;

  assign wsz = DW'(image_width);
  assign hsz = DW'(image_height);
  assign w = (wsz < DW'(8)) ? DW'(8) : ((wsz > DW'(MAX_COLS)) ? DW'(MAX_COLS) : wsz);
  assign h = (hsz < DW'(8)) ? DW'(8) : ((hsz > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : hsz);

  assign wrap  = (DW'(row_count) >= h) || (DW'(col_count) >= w);
  assign cc    = wrap ? '0 : DW'(col_count);
  assign rc    = wrap ? '0 : DW'(row_count);
  assign i_pos = cc - DW'(POST);
  assign j_pos = rc - DW'(POST);

  assign h_ok = (cc >= DW'(TAPS - 1)) && (i_pos >= DW'(HALF + 1))
             && (i_pos <= w - DW'(HALF + 2));
  assign v_ok = (rc >= DW'(TAPS - 1)) && (j_pos >= DW'(HALF + 1))
             && (j_pos <= h - DW'(HALF + 2));
  assign is_last = (j_pos == h - DW'(HALF + 2)) && (i_pos == w - DW'(HALF + 2));

  assign size_we = cfg_we && ((cfg_index == scf_pkg::REG_WIDTH)
                           || (cfg_index == scf_pkg::REG_HEIGHT));

  assign st.h_ok     = h_ok;
  assign st.v_ok     = item_v;
  assign st.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < scf_pkg::NCOEF; k++) begin
        coef[k] <= (scf_pkg::CIDX_W'(k) == scf_pkg::COEF_CENTER_IDX)
                 ? scf_pkg::COEF_CENTER_RESET : '0;
      end
      image_width  <= scf_pkg::SIZE_RESET;
      image_height <= scf_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      for (int k = 0; k < scf_pkg::NCOEF; k++) begin
        if (cfg_index == scf_pkg::CFG_IDX_W'(k)) begin
          coef[k] <= cfg_data;
        end
      end
      if (cfg_index == scf_pkg::REG_WIDTH) begin
        image_width <= cfg_data[scf_pkg::SIZE_W-1:0];
      end
      if (cfg_index == scf_pkg::REG_HEIGHT) begin
        image_height <= cfg_data[scf_pkg::SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || size_we) begin
      col_count <= '0;
      row_count <= '0;
      for (int k = 0; k < LINES; k++) begin
        row_window[k] <= '0;
      end
    end else if (cmd.accept) begin
      for (int k = LINES - 1; k > 0; k--) begin
        row_window[k] <= row_window[k-1];
      end
      row_window[0] <= pixel;
      if (cc + DW'(1) >= w) begin
        col_count <= '0;
        row_count <= (rc + DW'(1) >= h) ? '0 : ROW_W'(rc + DW'(1));
      end else begin
        col_count <= COL_W'(cc + DW'(1));
        row_count <= ROW_W'(rc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (cmd.accept) begin
      item_v <= h_ok && v_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int k = 0; k < TAPS - 1; k++) begin
        hsamp[k] <= row_window[TAPS - 2 - k];
      end
      hsamp[TAPS-1] <= pixel;
      item_col  <= COL_W'(i_pos);
      item_row  <= ROW_W'(j_pos);
      item_last <= is_last;
    end
  end

  always_comb begin
    for (int k = 0; k < LINES - 1; k++) begin
      wr_word[k*VW +: VW] = rd_word[(k+1)*VW +: VW];
    end
    wr_word[(LINES-1)*VW +: VW] = acc_sat;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_word <= mem[COL_W'(i_pos)];
    end
    if (cmd.mem_wr) begin
      mem[item_col] <= wr_word;
    end
  end

  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      vsamp[k] = $signed(rd_word[k*VW +: VW]);
    end
    vsamp[TAPS-1] = hres;
    opa = cmd.pass_v ? vsamp[cmd.tap[TAP_W-1:0]]
                     : VW'(hsamp[cmd.tap[TAP_W-1:0]]);
    opb = coef[scf_pkg::CIDX_W'(cmd.tap)];
  end

  assign acc_sat = scf_pkg::sat24(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= opa * opb;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + scf_pkg::ACC_W'(prod);
    end
    if (cmd.mem_wr) begin
      hres <= acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value   <= acc_sat;
      out_row <= scf_pkg::POS_W'(item_row);
      out_col <= scf_pkg::POS_W'(item_col);
      last    <= item_last;
    end
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS  = scf_pkg::DEF_TAPS;
  localparam int HALF  = (TAPS - 1) / 2;
  localparam int POST  = TAPS - 1 - HALF;
  localparam int LINES = TAPS - 1;
  localparam int unsigned MIN_DIM = 8;
  localparam int DRAIN_CYCLES = 4 * TAPS + 20;
  localparam longint LIMIT_CYCLES = 2000000;
  localparam longint VAL_MAX = 64'sd8388607;
  localparam longint VAL_MIN = -64'sd8388608;
  localparam logic [scf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [scf_pkg::VAL_W-1:0] value;
    logic [scf_pkg::POS_W-1:0]        row;
    logic [scf_pkg::POS_W-1:0]        col;
    logic                             last;
  } filtered_pixel_t;

  class conv_scoreboard;
    logic signed [scf_pkg::COEF_W-1:0] coef [scf_pkg::NCOEF];
    logic [scf_pkg::SIZE_W-1:0]        width_reg;
    logic [scf_pkg::SIZE_W-1:0]        height_reg;
    logic signed [scf_pkg::PIX_W-1:0]  window [TAPS-1];
    logic signed [scf_pkg::VAL_W-1:0]  line_store [LINES][scf_pkg::DEF_MAX_COLS];
    int unsigned                       row_pos;
    int unsigned                       col_pos;
    filtered_pixel_t                   expected_q[$];
    int                                errors;

    function new();
      foreach (coef[k]) coef[k] = '0;
      coef[scf_pkg::COEF_CENTER_IDX] = scf_pkg::COEF_CENTER_RESET;
      width_reg = scf_pkg::SIZE_RESET;
      height_reg = scf_pkg::SIZE_RESET;
      errors = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      row_pos = 0;
      col_pos = 0;
      foreach (window[k]) window[k] = '0;
    endfunction

    function int unsigned clamp_dim(logic [scf_pkg::SIZE_W-1:0] v, int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned frame_pixels();
      return clamp_dim(width_reg, scf_pkg::DEF_MAX_COLS)
           * clamp_dim(height_reg, scf_pkg::DEF_MAX_ROWS);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic signed [scf_pkg::VAL_W-1:0] scale_saturate(longint acc);
      longint sh;
      sh = acc >>> scf_pkg::FRAC;
      if (sh > VAL_MAX) return VAL_MAX[scf_pkg::VAL_W-1:0];
      if (sh < VAL_MIN) return VAL_MIN[scf_pkg::VAL_W-1:0];
      return sh[scf_pkg::VAL_W-1:0];
    endfunction

    function void write_reg(logic [scf_pkg::CFG_IDX_W-1:0] idx,
                            logic [scf_pkg::COEF_W-1:0] data);
      if (idx < scf_pkg::NCOEF) begin
        coef[idx] = data;
      end else if (idx == scf_pkg::REG_WIDTH) begin
        width_reg = data[scf_pkg::SIZE_W-1:0];
        restart_frame();
      end else if (idx == scf_pkg::REG_HEIGHT) begin
        height_reg = data[scf_pkg::SIZE_W-1:0];
        restart_frame();
      end
    endfunction

    function void note_pixel(logic [scf_pkg::PIX_W-1:0] data);
      int unsigned w, h, r, c, i, j;
      longint acc;
      int sample;
      logic signed [scf_pkg::VAL_W-1:0] hres;
      filtered_pixel_t res;
      w = clamp_dim(width_reg, scf_pkg::DEF_MAX_COLS);
      h = clamp_dim(height_reg, scf_pkg::DEF_MAX_ROWS);
      r = row_pos;
      c = col_pos;
      if (r >= h || c >= w) begin
        r = 0;
        c = 0;
      end
      i = c - POST;
      if (c >= TAPS - 1 && i >= HALF + 1 && i <= w - HALF - 2) begin
        acc = 0;
        for (int k = 0; k < TAPS; k++) begin
          sample = (k == TAPS - 1) ? $signed(data) : window[TAPS - 2 - k];
          acc += longint'(sample) * longint'(coef[k]);
        end
        hres = scale_saturate(acc);
        j = r - POST;
        if (r >= TAPS - 1 && j >= HALF + 1 && j <= h - HALF - 2) begin
          acc = 0;
          for (int k = 0; k < TAPS; k++) begin
            sample = (k == TAPS - 1) ? hres : line_store[(r + k) % LINES][i];
            acc += longint'(sample) * longint'(coef[k]);
          end
          res.value = scale_saturate(acc);
          res.row = scf_pkg::POS_W'(j);
          res.col = scf_pkg::POS_W'(i);
          res.last = (j == h - HALF - 2) && (i == w - HALF - 2);
          expected_q.push_back(res);
        end
        line_store[r % LINES][i] = hres;
      end
      for (int k = TAPS - 2; k > 0; k--) window[k] = window[k - 1];
      window[0] = data;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [scf_pkg::OUT_DATA_W-1:0] data, logic last_bit);
      filtered_pixel_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual value %0d row %0d col %0d last %0b",
                 $time, $signed(data[scf_pkg::VAL_W-1:0]),
                 data[scf_pkg::VAL_W +: scf_pkg::POS_W],
                 data[scf_pkg::VAL_W + scf_pkg::POS_W +: scf_pkg::POS_W], last_bit);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("value", exp_r.value, $signed(data[scf_pkg::VAL_W-1:0]));
      compare_field("row", exp_r.row, data[scf_pkg::VAL_W +: scf_pkg::POS_W]);
      compare_field("col", exp_r.col,
                    data[scf_pkg::VAL_W + scf_pkg::POS_W +: scf_pkg::POS_W]);
      compare_field("last", exp_r.last, last_bit);
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [scf_pkg::IN_DATA_W-1:0]     s_tdata;
  logic                              m_tvalid;
  logic                              m_tready;
  logic [scf_pkg::OUT_DATA_W-1:0]    m_tdata;
  logic                              m_tlast;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [scf_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [scf_pkg::COEF_W-1:0]        cfg_data;

  conv_scoreboard sb;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  logic        sender_quiet = 1'b0;
  longint      cycle_count = 0;

  separable_conv2d_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10ns clk = 1'b1;
    #10ns clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_pixel(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end
  end

  // The receiver runs on its own; a long hold-off lets the block fill up and stall its input.
  initial begin
    int unsigned hold_left;
    int unsigned span;
    logic        quiet;
    m_tready = 1'b0;
    hold_left = 0;
    span = 0;
    quiet = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (span == 0) begin
        span = 64;
        quiet = ($urandom_range(3) == 0);
      end
      span--;
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [scf_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [scf_pkg::COEF_W-1:0] rand_coef();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h4000;
      3: return 16'h0000;
      4: return 16'($urandom_range(2048)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [scf_pkg::COEF_W-1:0] rand_dim();
    case ($urandom_range(19))
      0, 1, 2: return {5'($urandom), 11'($urandom_range(MIN_DIM - 1))};
      3, 4: return 16'($urandom_range(17, 24));
      default: return 16'($urandom_range(MIN_DIM, 16));
    endcase
  endfunction

  task automatic send_pixel(input logic [scf_pkg::PIX_W-1:0] px);
    int unsigned pct;
    pct = sender_quiet ? 0 : idle_pct;
    while ($urandom_range(99) < pct) @(negedge clk) s_tvalid <= 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= px;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) send_pixel(rand_pixel());
  endtask

  task automatic write_cfg(input logic [scf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scf_pkg::COEF_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Waits for every predicted beat, then lets horizontal-only work finish.
  task automatic settle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic config_round();
    for (int k = 0; k < scf_pkg::NCOEF; k++) begin
      if ($urandom_range(1) == 1) write_cfg(scf_pkg::CFG_IDX_W'(k), rand_coef());
    end
    if ($urandom_range(9) < 7) write_cfg(scf_pkg::REG_WIDTH, rand_dim());
    if ($urandom_range(9) < 7) write_cfg(scf_pkg::REG_HEIGHT, rand_dim());
    if ($urandom_range(9) == 0) write_cfg(REG_UNUSED, 16'($urandom));
  endtask

  initial begin
    logic [scf_pkg::PIX_W-1:0] pattern [8];
    int unsigned               sent;
    int unsigned               count;
    sb = new();
    pattern = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
                16'h00FF};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reset coefficients pass pixels through unchanged.
    for (int n = 0; n < 6; n++) send_pixel(pattern[n]);
    settle();
    write_cfg(scf_pkg::REG_WIDTH, 16'd8);
    write_cfg(scf_pkg::REG_HEIGHT, 16'd8);
    for (int n = 0; n < 64; n++) send_pixel(pattern[(n * 3 + n / 8) % 8]);
    settle();

    // Coefficient extremes, sizes below range, the width with junk in the unused bits.
    for (int k = 0; k < scf_pkg::NCOEF; k++) write_cfg(scf_pkg::CFG_IDX_W'(k), 16'h8000);
    write_cfg(scf_pkg::REG_WIDTH, 16'hF803);
    write_cfg(scf_pkg::REG_HEIGHT, 16'h0000);
    for (int n = 0; n < 64; n++) send_pixel((n % 3 == 0) ? 16'h8000 : 16'h7FFF);
    settle();
    for (int k = 0; k < scf_pkg::NCOEF; k++) write_cfg(scf_pkg::CFG_IDX_W'(k), 16'h7FFF);
    write_cfg(REG_UNUSED, 16'hFFFF);
    for (int n = 0; n < 64; n++) send_pixel((n % 2 == 0) ? 16'h8000 : 16'h7FFF);

    // A size write in the middle of a frame restarts it.
    send_random(30);
    settle();
    write_cfg(scf_pkg::REG_WIDTH, 16'd9);
    send_random(72);
    settle();

    // Largest frame dimensions, width given above range; only the start of each frame is sent.
    for (int k = 0; k < scf_pkg::NCOEF; k++) write_cfg(scf_pkg::CFG_IDX_W'(k), rand_coef());
    write_cfg(scf_pkg::REG_WIDTH, 16'h07FF);
    write_cfg(scf_pkg::REG_HEIGHT, 16'd8);
    send_random(120);
    settle();
    write_cfg(scf_pkg::REG_WIDTH, 16'd8);
    write_cfg(scf_pkg::REG_HEIGHT, 16'd1024);
    send_random(120);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 85;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 85;
        end
        default: begin
          idle_pct = 8;
          stall_pct = 8;
        end
      endcase
      sent = 0;
      if (p == 0) begin
        write_cfg(scf_pkg::REG_WIDTH, 16'd16);
        write_cfg(scf_pkg::REG_HEIGHT, 16'd12);
        hold_req = 600;
        send_random(sb.frame_pixels());
        settle();
      end
      while (sent < 120) begin
        config_round();
        if ($urandom_range(4) == 0) begin
          count = $urandom_range(1, sb.frame_pixels() - 1);
        end else begin
          count = sb.frame_pixels() * $urandom_range(1, 2);
        end
        sender_quiet = ($urandom_range(3) == 0);
        send_random(count);
        sent += count;
        settle();
      end
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
